FILE: rtl/max_tracking_stack_top_macros.svh
// Assertion helpers used by the checker file
`ifndef MAX_TRACKING_STACK_TOP_MACROS_SVH
`define MAX_TRACKING_STACK_TOP_MACROS_SVH

// same-cycle implication, held off during reset
`define MTS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, held off during reset
`define MTS_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/mts_pkg.sv
package mts_pkg;

  localparam int unsigned STACK_DEPTH = 1024;
  localparam int unsigned DATA_W      = 32;
  localparam int unsigned ADDR_W      = $clog2(STACK_DEPTH);
  localparam int unsigned CNT_W       = $clog2(STACK_DEPTH + 1);

  localparam logic OP_PUSH = 1'b0;
  localparam logic OP_POP  = 1'b1;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    MOP_HOLD  = 2'd0,
    MOP_LOAD  = 2'd1,
    MOP_CMP   = 2'd2,
    MOP_CLEAR = 2'd3
  } max_op_e;

  typedef struct packed {
    max_op_e                   op;
    logic signed [DATA_W-1:0]  data;
    logic        [ADDR_W-1:0]  pos;
  } max_ctl_t;

  typedef struct packed {
    logic                      present;
    logic signed [DATA_W-1:0]  value;
    logic        [ADDR_W-1:0]  pos;
  } max_stat_t;

  typedef struct packed {
    status_e                   status;
    logic signed [DATA_W-1:0]  popped_value;
    logic                      max_valid;
    logic signed [DATA_W-1:0]  max_value;
    logic        [CNT_W-1:0]   entry_count;
  } result_t;

endpackage

FILE: rtl/mts_if.sv
interface mts_in_if import mts_pkg::*;
  ;
  logic                     valid;
  logic                     ready;
  logic                     operation;
  logic signed [DATA_W-1:0] value;

  modport source (output valid, output operation, output value, input ready);
  modport sink   (input valid, input operation, input value, output ready);
endinterface

interface mts_out_if import mts_pkg::*;
  ;
  logic                     valid;
  logic                     ready;
  logic [1:0]               status;
  logic signed [DATA_W-1:0] popped_value;
  logic                     max_valid;
  logic signed [DATA_W-1:0] max_value;
  logic [CNT_W-1:0]         entry_count;

  modport source (output valid, output status, output popped_value, output max_valid,
                  output max_value, output entry_count, input ready);
  modport sink   (input valid, input status, input popped_value, input max_valid,
                  input max_value, input entry_count, output ready);
endinterface

FILE: rtl/max_tracking_stack_top.sv
// Channel | Dir | Beat fields
// in_if_i | in  | operation, value
// out_if_o| out | status, popped_value, max_valid, max_value, entry_count
//
// Push and pop on an empty stack need no store read; a pop reads the store
// once, and popping the maximum entry at index t then reads each entry below
// it through the shared compare unit. A new beat is taken in idle, once the
// result register is free or drained in the same cycle. Reset clears control
// state, count and maximum, not the store. Stalls hold the result register.
module max_tracking_stack_top import mts_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  mts_in_if.sink     in_if_i,
  mts_out_if.source  out_if_o
);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_POP_RD = 2'd1;
  localparam logic [1:0] S_SCAN   = 2'd2;

  logic [1:0]         state_q, state_d;
  logic [CNT_W-1:0]   fill_q, fill_d;
  logic [ADDR_W-1:0]  idx_q, idx_d;
  logic               first_q, first_d;
  logic [DATA_W-1:0]  popped_q, popped_d;
  logic               out_valid_q, out_valid_d;
  result_t            res_q, res_d;

  logic               accept;
  logic               we;
  logic [ADDR_W-1:0]  raddr;
  logic [DATA_W-1:0]  rdata;
  logic [CNT_W-1:0]   top_cnt;
  max_ctl_t           ctl;
  max_stat_t          mx_cur, mx_nxt;
  logic               emit;
  status_e            emit_status;
  logic [DATA_W-1:0]  emit_popped;

  assign in_if_i.ready = (state_q == S_IDLE) && (!out_valid_q || out_if_o.ready);
  assign accept        = in_if_i.valid && in_if_i.ready;
  assign top_cnt       = fill_q - CNT_W'(1);

  mts_store u_store (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (fill_q[ADDR_W-1:0]),
    .wdata_i (in_if_i.value),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  mts_max_unit u_max (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (ctl),
    .cur_o  (mx_cur),
    .nxt_o  (mx_nxt)
  );

  always_comb begin
    state_d     = state_q;
    fill_d      = fill_q;
    idx_d       = idx_q;
    first_d     = first_q;
    popped_d    = popped_q;
    we          = 1'b0;
    raddr       = idx_q;
    ctl         = '{op: MOP_HOLD, data: rdata, pos: idx_q};
    emit        = 1'b0;
    emit_status = ST_DONE;
    emit_popped = '0;

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          if (in_if_i.operation == OP_PUSH) begin
            emit = 1'b1;
            if (fill_q == CNT_W'(STACK_DEPTH)) begin
              emit_status = ST_FULL;
            end else begin
              we       = 1'b1;
              ctl.op   = mx_cur.present ? MOP_CMP : MOP_LOAD;
              ctl.data = in_if_i.value;
              ctl.pos  = fill_q[ADDR_W-1:0];
              fill_d   = fill_q + CNT_W'(1);
            end
          end else if (fill_q == '0) begin
            emit        = 1'b1;
            emit_status = ST_EMPTY;
          end else begin
            raddr   = top_cnt[ADDR_W-1:0];
            idx_d   = top_cnt[ADDR_W-1:0];
            state_d = S_POP_RD;
          end
        end
      end
      S_POP_RD: begin
        popped_d = rdata;
        fill_d   = CNT_W'(idx_q);
        if (idx_q == '0) begin
          ctl.op      = MOP_CLEAR;
          emit        = 1'b1;
          emit_popped = rdata;
          state_d     = S_IDLE;
        end else if (mx_cur.pos == idx_q) begin
          raddr   = idx_q - ADDR_W'(1);
          idx_d   = idx_q - ADDR_W'(1);
          first_d = 1'b1;
          state_d = S_SCAN;
        end else begin
          emit        = 1'b1;
          emit_popped = rdata;
          state_d     = S_IDLE;
        end
      end
      S_SCAN: begin
        ctl.op  = first_q ? MOP_LOAD : MOP_CMP;
        first_d = 1'b0;
        if (idx_q == '0) begin
          emit        = 1'b1;
          emit_popped = popped_q;
          state_d     = S_IDLE;
        end else begin
          raddr = idx_q - ADDR_W'(1);
          idx_d = idx_q - ADDR_W'(1);
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q && !out_if_o.ready;
    res_d       = res_q;
    if (emit) begin
      out_valid_d = 1'b1;
      res_d = '{status:       emit_status,
                popped_value: emit_popped,
                max_valid:    mx_nxt.present,
                max_value:    mx_nxt.present ? mx_nxt.value : '0,
                entry_count:  fill_d};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      fill_q      <= '0;
      idx_q       <= '0;
      first_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      fill_q      <= fill_d;
      idx_q       <= idx_d;
      first_q     <= first_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    popped_q <= popped_d;
    res_q    <= res_d;
  end

  assign out_if_o.valid        = out_valid_q;
  assign out_if_o.status       = res_q.status;
  assign out_if_o.popped_value = res_q.popped_value;
  assign out_if_o.max_valid    = res_q.max_valid;
  assign out_if_o.max_value    = res_q.max_value;
  assign out_if_o.entry_count  = res_q.entry_count;

endmodule

FILE: rtl/mts_store.sv
module mts_store import mts_pkg::*; (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [DATA_W-1:0] wdata_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [DATA_W-1:0] rdata_o
);

  logic [DATA_W-1:0] mem_q [STACK_DEPTH];
  logic [DATA_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/mts_max_unit.sv
module mts_max_unit import mts_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  max_ctl_t  ctl_i,
  output max_stat_t cur_o,
  output max_stat_t nxt_o
);

  logic                     present_q, present_d;
  logic signed [DATA_W-1:0] value_q, value_d;
  logic [ADDR_W-1:0]        pos_q, pos_d;
  logic                     greater;

  assign greater = ctl_i.data > value_q;

  always_comb begin
    present_d = present_q;
    value_d   = value_q;
    pos_d     = pos_q;
    case (ctl_i.op)
      MOP_LOAD: begin
        present_d = 1'b1;
        value_d   = ctl_i.data;
        pos_d     = ctl_i.pos;
      end
      MOP_CMP: begin
        if (greater) begin
          value_d = ctl_i.data;
          pos_d   = ctl_i.pos;
        end
      end
      MOP_CLEAR: begin
        present_d = 1'b0;
        value_d   = '0;
        pos_d     = '0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      present_q <= 1'b0;
      value_q   <= '0;
      pos_q     <= '0;
    end else begin
      present_q <= present_d;
      value_q   <= value_d;
      pos_q     <= pos_d;
    end
  end

  assign cur_o = '{present: present_q, value: value_q, pos: pos_q};
  assign nxt_o = '{present: present_d, value: value_d, pos: pos_d};

endmodule

FILE: rtl/mts_checker.sv
`include "max_tracking_stack_top_macros.svh"

module mts_checker import mts_pkg::*; (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              out_valid_i,
  input logic              out_ready_i,
  input logic [1:0]        status_i,
  input logic [DATA_W-1:0] popped_value_i,
  input logic              max_valid_i,
  input logic [DATA_W-1:0] max_value_i,
  input logic [CNT_W-1:0]  entry_count_i
);

  `MTS_ASSERT_IMP(a_max_tracks_count, out_valid_i, max_valid_i == (entry_count_i != '0), "max_valid disagrees with entry_count")
  `MTS_ASSERT_IMP(a_empty_max_zero, out_valid_i && !max_valid_i, max_value_i == '0, "max_value nonzero on empty stack")
  `MTS_ASSERT_IMP(a_full_flag, out_valid_i && status_i == ST_FULL, entry_count_i == CNT_W'(STACK_DEPTH), "full flag below depth")
  `MTS_ASSERT_IMP(a_empty_flag, out_valid_i && status_i == ST_EMPTY, entry_count_i == '0 && popped_value_i == '0, "empty flag on nonempty stack")
  `MTS_ASSERT_NXT(a_out_hold, out_valid_i && !out_ready_i, out_valid_i && $stable(entry_count_i) && $stable(max_value_i), "result beat changed while stalled")

endmodule

bind max_tracking_stack_top mts_checker u_mts_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .out_valid_i    (out_if_o.valid),
  .out_ready_i    (out_if_o.ready),
  .status_i       (out_if_o.status),
  .popped_value_i (out_if_o.popped_value),
  .max_valid_i    (out_if_o.max_valid),
  .max_value_i    (out_if_o.max_value),
  .entry_count_i  (out_if_o.entry_count)
);

FILE: test/tb_top.sv
module tb_top import mts_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic signed [DATA_W-1:0] MIN_WORD = {1'b1, {(DATA_W-1){1'b0}}};
  localparam logic signed [DATA_W-1:0] MAX_WORD = {1'b0, {(DATA_W-1){1'b1}}};
  localparam int unsigned MAX_PRINTED = 50;
  localparam int unsigned RESCAN_CYCLES = STACK_DEPTH + 100;

  class max_stack_model;
    logic signed [DATA_W-1:0] entries [STACK_DEPTH];
    int unsigned used;
    int unsigned top_max_idx;
    bit          have_max;
    result_t     due_results[$];
    int unsigned mismatches;

    function void apply_op(logic op, logic signed [DATA_W-1:0] value);
      result_t r;
      int unsigned best;
      r = '0;
      r.status = ST_DONE;
      if (op == OP_PUSH) begin
        if (used >= STACK_DEPTH) begin
          r.status = ST_FULL;
        end else begin
          entries[used] = value;
          if (!have_max) begin
            top_max_idx = used;
            have_max = 1'b1;
          end else if (value > entries[top_max_idx]) begin
            top_max_idx = used;
          end
          used++;
        end
      end else if (used == 0) begin
        r.status = ST_EMPTY;
      end else begin
        r.popped_value = entries[used-1];
        if (used == 1) begin
          have_max = 1'b0;
          top_max_idx = 0;
        end else if (top_max_idx == used - 1) begin
          best = used - 2;
          for (int i = int'(used) - 3; i >= 0; i--) begin
            if (entries[i] > entries[best]) best = i;
          end
          top_max_idx = best;
        end
        used--;
      end
      r.max_valid = have_max && used > 0;
      r.max_value = r.max_valid ? entries[top_max_idx] : '0;
      r.entry_count = CNT_W'(used);
      due_results.push_back(r);
    endfunction

    task report_mismatch(string msg);
      mismatches++;
      if (mismatches <= MAX_PRINTED) $display("mismatch at %0t: %s", $realtime, msg);
    endtask

    task check_result(result_t got);
      result_t want;
      if (due_results.size() == 0) begin
        report_mismatch("result beat with no result due");
      end else begin
        want = due_results.pop_front();
        if (got.status !== want.status)
          report_mismatch($sformatf("status %0d, want %0d", got.status, want.status));
        if (got.popped_value !== want.popped_value)
          report_mismatch($sformatf("popped_value %0d, want %0d",
                                    got.popped_value, want.popped_value));
        if (got.max_valid !== want.max_valid)
          report_mismatch($sformatf("max_valid %0b, want %0b", got.max_valid, want.max_valid));
        if (got.max_value !== want.max_value)
          report_mismatch($sformatf("max_value %0d, want %0d", got.max_value, want.max_value));
        if (got.entry_count !== want.entry_count)
          report_mismatch($sformatf("entry_count %0d, want %0d",
                                    got.entry_count, want.entry_count));
      end
    endtask
  endclass

  logic clk_i;
  logic rst_ni;
  bit   idle_on;
  max_stack_model stack_ref;

  mts_in_if  in_if();
  mts_out_if out_if();

  max_tracking_stack_top i_dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .in_if_i  (in_if),
    .out_if_o (out_if)
  );

  always #4 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    out_if.ready <= !(idle_on && $urandom_range(99) < 38);
  end

  always @(negedge clk_i) begin
    result_t got;
    if (rst_ni && out_if.valid && out_if.ready) begin
      got.status       = status_e'(out_if.status);
      got.popped_value = out_if.popped_value;
      got.max_valid    = out_if.max_valid;
      got.max_value    = out_if.max_value;
      got.entry_count  = out_if.entry_count;
      stack_ref.check_result(got);
    end
  end

  function automatic logic signed [DATA_W-1:0] rand_word();
    case ($urandom_range(9))
      0: return MIN_WORD;
      1: return MAX_WORD;
      2: return '1;
      3, 4, 5: return DATA_W'(int'($urandom_range(8)) - 4);
      default: return DATA_W'($urandom);
    endcase
  endfunction

  task automatic send_op(input logic op, input logic signed [DATA_W-1:0] value);
    bit taken;
    while (idle_on && $urandom_range(99) < 38) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_if.valid     <= 1'b1;
    in_if.operation <= op;
    in_if.value     <= value;
    do begin
      @(negedge clk_i);
      taken = in_if.ready;
      if (taken) stack_ref.apply_op(op, value);
      @(posedge clk_i);
    end while (!taken);
  endtask

  task automatic push(input logic signed [DATA_W-1:0] value);
    send_op(OP_PUSH, value);
  endtask

  task automatic pop();
    send_op(OP_POP, rand_word());
  endtask

  task automatic wait_drained();
    in_if.valid <= 1'b0;
    while (stack_ref.due_results.size() != 0) @(posedge clk_i);
  endtask

  initial begin
    #100_000_000;
    $display("TB_ERROR");
    $finish;
  end

  initial begin
    stack_ref = new();
    clk_i = 1'b0;
    rst_ni = 1'b0;
    idle_on = 1'b1;
    in_if.valid = 1'b0;
    in_if.operation = OP_PUSH;
    in_if.value = '0;
    out_if.ready = 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    pop();
    push(MIN_WORD);
    push(MIN_WORD);
    push(5);
    pop();
    pop();
    pop();
    push(MAX_WORD);
    push('1);
    push(MAX_WORD);
    push(0);
    pop();
    pop();
    pop();
    pop();
    push(7);
    push(7);
    push(9);
    pop();
    pop();
    pop();
    pop();
    wait_drained();

    idle_on = 1'b0;
    for (int n = 0; n < 80; n++) begin
      if (n == 40) idle_on = 1'b1;
      if ($urandom_range(99) < (stack_ref.used > 12 ? 70 : 45)) pop();
      else push(rand_word());
    end
    wait_drained();

    while (stack_ref.used < STACK_DEPTH) begin
      if ($urandom_range(99) < 3) pop();
      else push(rand_word());
    end
    repeat (6) push(rand_word());
    for (int n = 0; n < 30; n++) begin
      if ($urandom_range(99) < 55) pop();
      else push(MAX_WORD - DATA_W'($urandom_range(15)));
    end

    wait_drained();
    repeat (RESCAN_CYCLES) @(posedge clk_i);
    if (stack_ref.due_results.size() != 0)
      stack_ref.report_mismatch($sformatf("%0d results never arrived",
                                          stack_ref.due_results.size()));
    if (stack_ref.mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end
endmodule

FILE: filelist.f
+incdir+rtl
rtl/mts_pkg.sv
rtl/mts_if.sv
rtl/mts_store.sv
rtl/mts_max_unit.sv
rtl/max_tracking_stack_top.sv
rtl/mts_checker.sv
test/tb_top.sv
